[design/bcpe_pkg.sv]
// Shared types, constants and the binomial table of the Bezier point evaluator.
`timescale 1ns / 1ps
`default_nettype none

package bcpe_pkg;

  localparam int MAX_POINTS  = 8;
  localparam int COORD_W     = 32;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int SLOT_W      = 3;
  localparam int CNT_W       = 4;
  localparam int T_FRAC      = 16;
  localparam int T_W         = T_FRAC + 1;
  localparam int PROD_W      = 2 * T_W;
  localparam int BINOM_W     = 10;
  localparam int WEIGHT_W    = 34;
  localparam int W_LO_W      = 17;
  localparam int W_HI_W      = WEIGHT_W - W_LO_W;
  localparam int ACC_W       = COORD_W + WEIGHT_W + IDX_W;
  localparam int ROUND_SHIFT = 2 * T_FRAC;
  localparam int Q_W         = ACC_W - ROUND_SHIFT;
  localparam int POINT_W     = 3 * COORD_W;

  localparam logic [T_W-1:0]    T_ONE     = T_W'(1 << T_FRAC);
  localparam logic [PROD_W-1:0] POW_HALF  = PROD_W'(1 << (T_FRAC - 1));
  localparam logic [CNT_W-1:0]  CNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(4);

  localparam logic       ACT_LOAD = 1'b0;
  localparam logic       ACT_EVAL = 1'b1;

  typedef struct packed {
    logic load_point;
    logic start_eval;
    logic power_step;
    logic weight_prod;
    logic weight_scale;
    logic mac_lo;
    logic mac_hi;
    logic round_res;
    logic out_load;
  } bcpe_cmd_t;

  // Entry (m, k) of Pascal's triangle, folded to constants by synthesis.
  function automatic logic [BINOM_W-1:0] binom_coef(input logic [IDX_W-1:0] m,
                                                     input logic [IDX_W-1:0] k);
    logic [BINOM_W-1:0] pascal [MAX_POINTS][MAX_POINTS];
    for (int r = 0; r < MAX_POINTS; r++) begin
      for (int c = 0; c < MAX_POINTS; c++) begin
        if (c == 0) begin
          pascal[r][c] = BINOM_W'(1);
        end else if (r == 0) begin
          pascal[r][c] = '0;
        end else begin
          pascal[r][c] = pascal[r-1][c-1] + pascal[r-1][c];
        end
      end
    end
    return pascal[m][k];
  endfunction

endpackage

`default_nettype wire

[design/bcpe_ctrl.sv]
// Sequencer of the Bezier point evaluator: handshakes and datapath commands.
`timescale 1ns / 1ps
`default_nettype none

module bcpe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               action,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire logic               idx_last,
  output bcpe_pkg::bcpe_cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_POWER  = 8'b0000_0010,
    S_WPROD  = 8'b0000_0100,
    S_WSCALE = 8'b0000_1000,
    S_MAC_LO = 8'b0001_0000,
    S_MAC_HI = 8'b0010_0000,
    S_ROUND  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == bcpe_pkg::ACT_EVAL) begin
            cmd.start_eval = 1'b1;
            state_next     = S_POWER;
          end else begin
            cmd.load_point = 1'b1;
          end
        end
      end
      S_POWER: begin
        cmd.power_step = 1'b1;
        if (idx_last) begin
          state_next = S_WPROD;
        end
      end
      S_WPROD: begin
        cmd.weight_prod = 1'b1;
        state_next      = S_WSCALE;
      end
      S_WSCALE: begin
        cmd.weight_scale = 1'b1;
        state_next       = S_MAC_LO;
      end
      S_MAC_LO: begin
        cmd.mac_lo = 1'b1;
        state_next = S_MAC_HI;
      end
      S_MAC_HI: begin
        cmd.mac_hi = 1'b1;
        state_next = idx_last ? S_ROUND : S_WPROD;
      end
      S_ROUND: begin
        cmd.round_res = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[design/bcpe_datapath.sv]
// Datapath of the Bezier point evaluator: point store, powers, weights, MAC lanes.
`timescale 1ns / 1ps
`default_nettype none

module bcpe_datapath (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire bcpe_pkg::bcpe_cmd_t                         cmd,
  output logic                                             idx_last,
  input  wire logic                                        cfg_we,
  input  wire logic        [bcpe_pkg::CNT_W-1:0]           cfg_data,
  input  wire logic        [bcpe_pkg::SLOT_W-1:0]          point_index,
  input  wire logic signed [bcpe_pkg::COORD_W-1:0]         coord_x,
  input  wire logic signed [bcpe_pkg::COORD_W-1:0]         coord_y,
  input  wire logic signed [bcpe_pkg::COORD_W-1:0]         coord_z,
  input  wire logic        [bcpe_pkg::T_W-1:0]             param_t,
  output logic signed      [bcpe_pkg::COORD_W-1:0]         point_x,
  output logic signed      [bcpe_pkg::COORD_W-1:0]         point_y,
  output logic signed      [bcpe_pkg::COORD_W-1:0]         point_z
);

  logic [bcpe_pkg::POINT_W-1:0]  store [bcpe_pkg::MAX_POINTS];
  logic [bcpe_pkg::POINT_W-1:0]  rd_point;

  logic [bcpe_pkg::CNT_W-1:0]    point_count;
  logic [bcpe_pkg::CNT_W-1:0]    n_clamp;
  logic [bcpe_pkg::T_W-1:0]      tc_clamp;

  logic [bcpe_pkg::T_W-1:0]      tc, uc, tcur, ucur;
  logic [bcpe_pkg::T_W-1:0]      tpow [bcpe_pkg::MAX_POINTS];
  logic [bcpe_pkg::T_W-1:0]      upow [bcpe_pkg::MAX_POINTS];
  logic [bcpe_pkg::PROD_W-1:0]   tmul, umul;
  logic [bcpe_pkg::T_W-1:0]      tnext, unext;
  logic [bcpe_pkg::IDX_W-1:0]    m, idx;

  logic [bcpe_pkg::PROD_W-1:0]   ab;
  logic [bcpe_pkg::BINOM_W-1:0]  binom;
  logic [bcpe_pkg::WEIGHT_W-1:0] weight;

  logic signed [bcpe_pkg::COORD_W-1:0]                  coord   [3];
  logic signed [bcpe_pkg::COORD_W+bcpe_pkg::W_LO_W:0]   prod_lo [3];
  logic signed [bcpe_pkg::COORD_W+bcpe_pkg::W_HI_W:0]   prod_hi [3];
  logic signed [bcpe_pkg::ACC_W-1:0]                    acc     [3];
  logic signed [bcpe_pkg::ACC_W-1:0]                    rsum    [3];
  logic signed [bcpe_pkg::Q_W-1:0]                      q       [3];
  logic signed [bcpe_pkg::COORD_W-1:0]                  sat     [3];
  logic signed [bcpe_pkg::COORD_W-1:0]                  res     [3];

  always_comb begin
    if (point_count < bcpe_pkg::CNT_MIN) begin
      n_clamp = bcpe_pkg::CNT_MIN;
    end else if (point_count > bcpe_pkg::CNT_MAX) begin
      n_clamp = bcpe_pkg::CNT_MAX;
    end else begin
      n_clamp = point_count;
    end
    tc_clamp = (param_t > bcpe_pkg::T_ONE) ? bcpe_pkg::T_ONE : param_t;
  end

  assign tmul     = bcpe_pkg::PROD_W'(tcur) * bcpe_pkg::PROD_W'(tc) + bcpe_pkg::POW_HALF;
  assign umul     = bcpe_pkg::PROD_W'(ucur) * bcpe_pkg::PROD_W'(uc) + bcpe_pkg::POW_HALF;
  assign tnext    = tmul[bcpe_pkg::T_FRAC +: bcpe_pkg::T_W];
  assign unext    = umul[bcpe_pkg::T_FRAC +: bcpe_pkg::T_W];
  assign idx_last = (idx == m);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coord[k]   = rd_point[k*bcpe_pkg::COORD_W +: bcpe_pkg::COORD_W];
      prod_lo[k] = coord[k] * $signed({1'b0, weight[bcpe_pkg::W_LO_W-1:0]});
      prod_hi[k] = coord[k] * $signed({1'b0, weight[bcpe_pkg::WEIGHT_W-1:bcpe_pkg::W_LO_W]});
      rsum[k]    = acc[k] + (bcpe_pkg::ACC_W'(1) <<< (bcpe_pkg::ROUND_SHIFT - 1));
      q[k]       = rsum[k][bcpe_pkg::ACC_W-1:bcpe_pkg::ROUND_SHIFT];
      if ((&q[k][bcpe_pkg::Q_W-1:bcpe_pkg::COORD_W-1]) ||
          !(|q[k][bcpe_pkg::Q_W-1:bcpe_pkg::COORD_W-1])) begin
        sat[k] = q[k][bcpe_pkg::COORD_W-1:0];
      end else if (q[k][bcpe_pkg::Q_W-1]) begin
        sat[k] = {1'b1, {(bcpe_pkg::COORD_W-1){1'b0}}};
      end else begin
        sat[k] = {1'b0, {(bcpe_pkg::COORD_W-1){1'b1}}};
      end
    end
  end

  // point store: written by loads, read one slot per point step
  always_ff @(posedge clk) begin
    if (cmd.load_point && (int'(point_index) < bcpe_pkg::MAX_POINTS)) begin
      store[bcpe_pkg::IDX_W'(point_index)] <= {coord_z, coord_y, coord_x};
    end
    if (cmd.weight_prod) begin
      rd_point <= store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= bcpe_pkg::CNT_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      tc      <= tc_clamp;
      uc      <= bcpe_pkg::T_ONE - tc_clamp;
      m       <= bcpe_pkg::IDX_W'(n_clamp - bcpe_pkg::CNT_W'(1));
      tcur    <= bcpe_pkg::T_ONE;
      ucur    <= bcpe_pkg::T_ONE;
      tpow[0] <= bcpe_pkg::T_ONE;
      upow[0] <= bcpe_pkg::T_ONE;
      idx     <= bcpe_pkg::IDX_W'(1);
      for (int k = 0; k < 3; k++) begin
        acc[k] <= '0;
      end
    end
    if (cmd.power_step) begin
      tpow[idx] <= tnext;
      upow[idx] <= unext;
      tcur      <= tnext;
      ucur      <= unext;
      idx       <= idx_last ? '0 : idx + bcpe_pkg::IDX_W'(1);
    end
    if (cmd.weight_prod) begin
      ab    <= bcpe_pkg::PROD_W'(tpow[idx]) * bcpe_pkg::PROD_W'(upow[m - idx]);
      binom <= bcpe_pkg::binom_coef(m, idx);
    end
    if (cmd.weight_scale) begin
      weight <= bcpe_pkg::WEIGHT_W'(binom * ab);
    end
    if (cmd.mac_lo) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= acc[k] + bcpe_pkg::ACC_W'(prod_lo[k]);
      end
    end
    if (cmd.mac_hi) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= acc[k] + (bcpe_pkg::ACC_W'(prod_hi[k]) <<< bcpe_pkg::W_LO_W);
      end
      idx <= idx + bcpe_pkg::IDX_W'(1);
    end
    if (cmd.round_res) begin
      for (int k = 0; k < 3; k++) begin
        res[k] <= sat[k];
      end
    end
    if (cmd.out_load) begin
      point_x <= res[0];
      point_y <= res[1];
      point_z <= res[2];
    end
  end

endmodule

`default_nettype wire

[design/bezier_curve_point_evaluator.sv]
// Top level of the Bezier curve point evaluator.
// A load item (action 0) writes one control point into slot point_index; the
// three-bit index addresses every slot of the store. An evaluate item (action 1)
// returns the Bezier point at param_t (Q1.16, clamped to 1.0) over the first
// point_count stored points (clamped to 2..8), Q16.16, rounded to nearest and
// saturated. An evaluate runs through these steps: power steps build the powers
// of t and 1-t, then each point takes four steps (weight product, binomial scale,
// low and high halves of a 32x17 multiply per coordinate lane), then a rounding
// step and a load into the output register. The result waits there while the
// next item is taken; a following evaluate holds in its last step, with the
// input closed, until that result is transferred. Reading a slot that was never
// loaded gives an undefined result.
// point_count is written on the cfg channel, which is always ready, and should
// change only while idle.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_point_evaluator (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [bcpe_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 action,
  input  wire logic        [bcpe_pkg::SLOT_W-1:0]   point_index,
  input  wire logic signed [bcpe_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [bcpe_pkg::COORD_W-1:0]  coord_y,
  input  wire logic signed [bcpe_pkg::COORD_W-1:0]  coord_z,
  input  wire logic        [bcpe_pkg::T_W-1:0]      param_t,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [bcpe_pkg::COORD_W-1:0]  point_x,
  output logic signed      [bcpe_pkg::COORD_W-1:0]  point_y,
  output logic signed      [bcpe_pkg::COORD_W-1:0]  point_z
);

  bcpe_pkg::bcpe_cmd_t cmd;
  logic                idx_last;

  assign cfg_ready = 1'b1;

  bcpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .idx_last  (idx_last),
    .cmd       (cmd)
  );

  bcpe_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .idx_last    (idx_last),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .point_index (point_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .param_t     (param_t),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z)
  );

`ifndef NO_ASSERTIONS
  // an evaluate transfer keeps the input side closed for the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == bcpe_pkg::ACT_EVAL) |=> !in_ready)
    else $error("input accepted right after an evaluate transfer");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == bcpe_pkg::ACT_LOAD && !out_valid) |=> !out_valid)
    else $error("result raised by a load transfer");

  // at most one datapath command per cycle
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_point, cmd.start_eval, cmd.power_step, cmd.weight_prod,
              cmd.weight_scale, cmd.mac_lo, cmd.mac_hi, cmd.round_res, cmd.out_load}))
    else $error("more than one datapath command in a cycle");
`endif

endmodule

`default_nettype wire
